// ===== sv/ofd_pkg.sv =====
// Shared types and constants for the optical bit frame detector.
`default_nettype none

package ofd_pkg;

  localparam int SAMPLE_W      = 10;
  localparam int THRESH_W      = 11;
  localparam int FRAME_BITS_W  = 64;
  localparam int FRAME_LEN_W   = 7;
  localparam int WINDOW_W      = 8;

  localparam logic [THRESH_W-1:0]    THRESHOLD_RESET = 11'd100;
  localparam logic [WINDOW_W-1:0]    START_PATTERN   = 8'h81;
  localparam logic [WINDOW_W-1:0]    END_PATTERN     = 8'hFF;
  localparam logic [FRAME_LEN_W-1:0] WINDOW_BITS     = 7'd8;

  // One decided bit moving from the slicer to the framer.
  typedef struct packed {
    logic valid;
    logic value;
  } ofd_bit_t;

  // One result word before packing onto the output stream.
  typedef struct packed {
    logic [FRAME_LEN_W-1:0]  frame_length;
    logic [FRAME_BITS_W-1:0] frame_bits;
    logic                    overflow;
    logic                    frame_done;
    logic                    start_seen;
    logic                    bit_value;
  } ofd_result_t;

endpackage

`default_nettype wire

// ===== sv/ofd_slicer.sv =====
// Input register stage: threshold register and bit decision per sample.
`default_nettype none

module ofd_slicer
  import ofd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_wr_en,
  input  wire logic [THRESH_W-1:0] cfg_wr_data,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [SAMPLE_W-1:0] sample,
  input  wire logic                bit_ready,
  output ofd_bit_t                 bit_out
);

  logic [THRESH_W-1:0] threshold_r;
  logic                valid_r, valid_nxt;
  logic                value_r, value_nxt;

  assign in_ready = !valid_r || bit_ready;

  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    if (in_ready) begin
      valid_nxt = in_valid;
      // a sample strictly above the threshold reads as one
      value_nxt = ({1'b0, sample} > threshold_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RESET;
      valid_r     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        threshold_r <= cfg_wr_data;
      end
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign bit_out.valid = valid_r;
  assign bit_out.value = value_r;

endmodule

`default_nettype wire

// ===== sv/ofd_framer.sv =====
// Hunt/collect state machine for the frame buffer and the result register.
`default_nettype none

module ofd_framer
  import ofd_pkg::*;
#(
  parameter int MAX_FRAME_BITS = 64
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  ofd_bit_t  bit_in,
  output logic      bit_ready,
  output logic      res_valid,
  input  wire logic res_ready,
  output ofd_result_t res
);

  logic [MAX_FRAME_BITS-1:0] bit_buffer_r, bit_buffer_nxt;
  logic [FRAME_LEN_W-1:0]    bit_count_r, bit_count_nxt;
  logic                      in_frame_r, in_frame_nxt;
  logic                      res_valid_r, res_valid_nxt;
  ofd_result_t               res_r, res_nxt;
  logic                      accept;
  logic [MAX_FRAME_BITS-1:0] shifted;
  logic [WINDOW_W-1:0]       window;

  assign bit_ready = !res_valid_r || res_ready;
  assign accept    = bit_in.valid && bit_ready;
  assign shifted   = {bit_buffer_r[MAX_FRAME_BITS-2:0], bit_in.value};
  assign window    = shifted[WINDOW_W-1:0];

  always_comb begin
    bit_buffer_nxt = bit_buffer_r;
    bit_count_nxt  = bit_count_r;
    in_frame_nxt   = in_frame_r;
    res_valid_nxt  = res_valid_r;
    res_nxt        = res_r;
    if (bit_ready) begin
      res_valid_nxt = bit_in.valid;
    end
    if (accept) begin
      res_nxt            = '0;
      res_nxt.bit_value  = bit_in.value;
      if (!in_frame_r) begin
        // hunting: keep only the newest eight bits
        bit_buffer_nxt = MAX_FRAME_BITS'(window);
        if (window == START_PATTERN) begin
          in_frame_nxt       = 1'b1;
          res_nxt.start_seen = 1'b1;
        end
      end else if (bit_count_r >= FRAME_LEN_W'(MAX_FRAME_BITS)) begin
        // drop the frame and this bit
        res_nxt.overflow = 1'b1;
        bit_buffer_nxt   = '0;
        bit_count_nxt    = WINDOW_BITS;
        in_frame_nxt     = 1'b0;
      end else begin
        bit_buffer_nxt = shifted;
        bit_count_nxt  = bit_count_r + 1'b1;
        if (window == END_PATTERN) begin
          res_nxt.frame_done   = 1'b1;
          res_nxt.frame_bits   = FRAME_BITS_W'(shifted);
          res_nxt.frame_length = bit_count_r + 1'b1;
          bit_buffer_nxt       = '0;
          bit_count_nxt        = WINDOW_BITS;
          in_frame_nxt         = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_buffer_r <= '0;
      bit_count_r  <= WINDOW_BITS;
      in_frame_r   <= 1'b0;
      res_valid_r  <= 1'b0;
    end else begin
      bit_buffer_r <= bit_buffer_nxt;
      bit_count_r  <= bit_count_nxt;
      in_frame_r   <= in_frame_nxt;
      res_valid_r  <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

  a_done_not_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r |-> !(res_r.frame_done && res_r.overflow))
    else $error("frame_done and overflow on one word");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    bit_count_r <= FRAME_LEN_W'(MAX_FRAME_BITS))
    else $error("bit count past frame limit");

  a_done_back_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && res_nxt.frame_done) |=> (!in_frame_r && bit_count_r == WINDOW_BITS))
    else $error("framer did not return to hunting after frame end");

  a_hunt_window_only: assert property (@(posedge clk) disable iff (!rst_n)
    !in_frame_r |-> (bit_buffer_r[MAX_FRAME_BITS-1:WINDOW_W] == '0))
    else $error("stale bits above the hunt window");

  // the last start bit can open the end pattern, so the shortest frame is 15 bits
  a_min_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid_r && res_r.frame_done) |-> (res_r.frame_length >= 2 * WINDOW_BITS - 1))
    else $error("frame shorter than start plus end pattern");

endmodule

`default_nettype wire

// ===== sv/optical_bit_frame_detector_top.sv =====
// Optical bit frame detector: slices light samples into bits and frames them.
//
// Input stream: one light-sensor word per handshake, in_tdata[9:0] holds the
// sample. Each sample above the threshold register reads as a one.
// Output stream: exactly one result word per input word, in order. tlast
// marks the word on which a frame ends (the eight-ones end pattern); tdata
// then carries the whole frame, newest bit in bit zero, and its length.
// tuser flags the start pattern and a frame dropped for exceeding
// MAX_FRAME_BITS.
// Configuration: cfg_wr_en writes cfg_wr_data into the threshold register
// in the same cycle; write it only while no word is in flight.
// Pipeline: input words pass the slicer register, then the framer result
// register, on the way to the output. Throughput: one word per cycle while
// out_tready is high; the framer does a single shift and compare per cycle.
// Reset: threshold returns to 100, the framer goes back to hunting with an
// empty window, and both pipeline stages are emptied.
// Stalls: when out_tready is low, the result word holds, the slicer stage
// still takes one more word, and in_tready then drops until space frees up.
`default_nettype none

module optical_bit_frame_detector_top
  import ofd_pkg::*;
#(
  parameter int MAX_FRAME_BITS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [10:0] cfg_wr_data,   // threshold
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,      // [9:0] light_sample, rest zero
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata,     // [0] bit_value, [64:1] frame_bits,
                                          // [71:65] frame_length
  output logic             out_tlast,     // frame_done
  output logic [1:0]       out_tuser      // [0] start_seen, [1] overflow
);

  ofd_bit_t    slice_bit;
  logic        framer_ready;
  ofd_result_t res;

  ofd_slicer u_slicer (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .sample      (in_tdata[SAMPLE_W-1:0]),
    .bit_ready   (framer_ready),
    .bit_out     (slice_bit)
  );

  ofd_framer #(
    .MAX_FRAME_BITS (MAX_FRAME_BITS)
  ) u_framer (
    .clk       (clk),
    .rst_n     (rst_n),
    .bit_in    (slice_bit),
    .bit_ready (framer_ready),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {res.frame_length, res.frame_bits, res.bit_value};
  assign out_tlast = res.frame_done;
  assign out_tuser = {res.overflow, res.start_seen};

endmodule

`default_nettype wire

// ===== tb/sv/optical_bit_frame_detector_top_test.sv =====
// Self-checking testbench for the optical bit frame detector top level.
`default_nettype none

module optical_bit_frame_detector_top_test
  import ofd_pkg::*;
;

  localparam int MAX_FRAME_BITS   = 64;
  localparam int TAIL_CYCLES      = 8;
  localparam int LONG_HOLD        = 250;
  localparam int QUIET_LIMIT      = 3000;
  localparam int RANDOM_WORDS_END = 750;
  localparam int PHASE_WORDS      = 150;
  localparam logic [THRESH_W-1:0] THRESH_MAX     = 11'd1123;
  localparam logic [THRESH_W-1:0] SAMPLE_TOP     = 11'd1023;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_wr_en   = 1'b0;
  logic [10:0] cfg_wr_data = '0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata    = '0;      // [9:0] light_sample, rest zero
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [71:0] out_tdata;             // [0] bit_value, [64:1] frame_bits,
                                      // [71:65] frame_length
  logic        out_tlast;             // frame_done
  logic [1:0]  out_tuser;             // [0] start_seen, [1] overflow

  // Detector state as the testbench tracks it.
  logic [THRESH_W-1:0]     threshold   = THRESHOLD_RESET;
  logic [FRAME_BITS_W-1:0] frame_buf   = '0;
  logic [FRAME_LEN_W-1:0]  frame_count = WINDOW_BITS;
  bit                      in_frame    = 1'b0;

  ofd_result_t pending_detections[$];
  int          mismatches    = 0;
  int          words_sent    = 0;
  bit          idle_on       = 1'b1;
  int          hold_requests = 0;
  int          hold_served   = 0;
  int          hold_left     = 0;
  int          stall_left    = 0;

  optical_bit_frame_detector_top #(
    .MAX_FRAME_BITS(MAX_FRAME_BITS)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void clear_to_hunt();
    frame_buf   = '0;
    frame_count = WINDOW_BITS;
    in_frame    = 1'b0;
  endfunction

  function automatic ofd_result_t decode_sample(input logic [SAMPLE_W-1:0] sample);
    ofd_result_t r;
    logic        b;
    r = '0;
    b = ({1'b0, sample} > threshold);
    r.bit_value = b;
    if (!in_frame) begin
      frame_buf = {{(FRAME_BITS_W-WINDOW_W){1'b0}}, frame_buf[WINDOW_W-2:0], b};
      if (frame_buf[WINDOW_W-1:0] == START_PATTERN) begin
        in_frame     = 1'b1;
        r.start_seen = 1'b1;
      end
    end else if (frame_count >= MAX_FRAME_BITS) begin
      // drop the frame and this bit
      r.overflow = 1'b1;
      clear_to_hunt();
    end else begin
      frame_buf   = {frame_buf[FRAME_BITS_W-2:0], b};
      frame_count = frame_count + 1'b1;
      if (frame_buf[WINDOW_W-1:0] == END_PATTERN) begin
        r.frame_done   = 1'b1;
        r.frame_bits   = frame_buf;
        r.frame_length = frame_count;
        clear_to_hunt();
      end
    end
    return r;
  endfunction

  function automatic logic [SAMPLE_W-1:0] sample_for_bit(input bit one);
    if (threshold >= SAMPLE_TOP) return SAMPLE_W'($urandom_range(0, 1023));
    if (one) return SAMPLE_W'($urandom_range(threshold + 1, 1023));
    return SAMPLE_W'($urandom_range(0, threshold));
  endfunction

  task automatic send_sample(input logic [SAMPLE_W-1:0] sample);
    ofd_result_t res;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(16-SAMPLE_W){1'b0}}, sample};
    do @(posedge clk); while (!in_tready);
    res = decode_sample(sample);
    pending_detections.insert(pending_detections.size(), res);
    words_sent++;
  endtask

  task automatic send_bit(input bit one);
    send_sample(sample_for_bit(one));
  endtask

  // Start pattern, body with no run of eight ones, then optionally the end pattern.
  task automatic send_frame(input int body_len, input bit close);
    if (threshold < SAMPLE_TOP) begin
      while (in_frame) send_bit(1'b1);
      for (int i = 0; i < WINDOW_W; i++) send_bit(START_PATTERN[WINDOW_W-1-i]);
      for (int i = 0; i < body_len; i++)
        send_bit((i % 7 == 6 || i == body_len - 1) ? 1'b0 : 1'($urandom_range(0, 1)));
      if (close) repeat (WINDOW_W) send_bit(1'b1);
    end
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_detections.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Write only with nothing in flight and the input idle.
  task automatic write_threshold(input logic [THRESH_W-1:0] value);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    threshold = value;
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_check
    ofd_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_detections.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual tdata %h tlast %b tuser %b",
                 $time, out_tdata, out_tlast, out_tuser);
        mismatches++;
      end else begin
        want = pending_detections.pop_front();
        check_field("bit_value",    64'(want.bit_value),    64'(out_tdata[0]));
        check_field("frame_bits",   want.frame_bits,        out_tdata[64:1]);
        check_field("frame_length", 64'(want.frame_length), 64'(out_tdata[71:65]));
        check_field("frame_done",   64'(want.frame_done),   64'(out_tlast));
        check_field("start_seen",   64'(want.start_seen),   64'(out_tuser[0]));
        check_field("overflow",     64'(want.overflow),     64'(out_tuser[1]));
      end
    end
  end

  // Receiver: long holds on request, random stall bursts while idling is on.
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left   <= LONG_HOLD;
      out_tready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 16);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // Reset threshold, slicing edges, and the shortest frame.
  task automatic test_slicer_and_short_frame();
    send_sample(10'd0);
    send_sample(10'd100);
    send_sample(10'd101);
    send_sample(10'd1023);
    send_sample(10'd512);
    send_frame(0, 1'b1);
    drain_results();
  endtask

  task automatic test_threshold_extremes();
    write_threshold(11'd0);
    send_sample(10'd0);
    send_sample(10'd1);
    send_sample(10'd1023);
    write_threshold(THRESH_MAX);
    send_sample(10'd1023);
    send_sample(10'd0);
    send_sample(SAMPLE_W'($urandom_range(0, 1023)));
    drain_results();
    write_threshold(SAMPLE_TOP);
    send_sample(10'd1023);
    write_threshold(11'd1022);
    send_sample(10'd1022);
    send_sample(10'd1023);
    drain_results();
  endtask

  // Frame of exactly MAX_FRAME_BITS, a frame that never closes, one that
  // overflows inside its end pattern.
  task automatic test_frame_limits();
    write_threshold(11'd512);
    send_frame(MAX_FRAME_BITS - 2 * WINDOW_W, 1'b1);
    send_frame(MAX_FRAME_BITS - WINDOW_W + 1, 1'b0);
    send_frame(52, 1'b1);
    drain_results();
  endtask

  task automatic test_backpressure();
    idle_on = 1'b0;
    write_threshold(11'd300);
    hold_requests++;
    send_frame(10, 1'b1);
    repeat (20) send_sample(SAMPLE_W'($urandom_range(0, 1023)));
    drain_results();
  endtask

  task automatic test_random_traffic();
    int next_phase;
    int pick;
    next_phase = words_sent;
    while (words_sent < RANDOM_WORDS_END) begin
      if (words_sent >= next_phase) begin
        drain_results();
        case ($urandom_range(0, 7))
          0:       write_threshold(11'd0);
          1:       write_threshold(THRESH_MAX);
          2:       write_threshold(11'd1022);
          3:       write_threshold(SAMPLE_TOP);
          default: write_threshold(THRESH_W'($urandom_range(20, 1000)));
        endcase
        idle_on    = ($urandom_range(0, 3) != 0);
        next_phase = words_sent + PHASE_WORDS;
      end
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        send_frame(($urandom_range(0, 9) == 0) ? $urandom_range(40, 60)
                                               : $urandom_range(0, 20), 1'b1);
      end else if (pick == 7) begin
        send_frame($urandom_range(0, 10), 1'b0);
        repeat ($urandom_range(1, 8)) send_sample(SAMPLE_W'($urandom_range(0, 1023)));
      end else begin
        repeat ($urandom_range(1, 12)) send_sample(SAMPLE_W'($urandom_range(0, 1023)));
      end
    end
    drain_results();
  endtask

  task automatic test_steady_stream();
    idle_on = 1'b0;
    write_threshold(THRESH_W'($urandom_range(50, 900)));
    repeat (4) send_frame($urandom_range(0, 20), 1'b1);
    repeat (10) send_sample(SAMPLE_W'($urandom_range(0, 1023)));
    send_frame($urandom_range(0, 10), 1'b1);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_slicer_and_short_frame();
    test_threshold_extremes();
    test_frame_limits();
    test_backpressure();
    test_random_traffic();
    test_steady_stream();
    drain_results();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
sv/ofd_pkg.sv
sv/ofd_slicer.sv
sv/ofd_framer.sv
sv/optical_bit_frame_detector_top.sv
tb/sv/optical_bit_frame_detector_top_test.sv
